[hw/rtl/racb_pkg.sv]
package racb_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int OPD_W = 32;
    localparam int VAL_W = 48;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_COUNT = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic signed [VAL_W-1:0] S48_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] S48_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                 input logic [OPD_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({{(VAL_W-OPD_W+1){b[OPD_W-1]}}, b});
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? S48_MIN : S48_MAX;
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/range_add_count_below_unit.sv]
// Range add / count-below unit over a block-partitioned array of 48-bit values.
// Input stream (s_*): one command per transfer: load an element, add an amount
// to an index range, or count elements in a range below a threshold.
// Output stream (m_*): one transfer per count command, none for load or add.
// cfg_*: writes element_count; the user must do so only while the unit is idle,
// which the unit does not enforce. After reset the per-block offsets are cleared,
// one block per cycle for all ceil(MAX_ELEMENTS / BLOCK_SIZE) blocks; s_tready
// stays low meanwhile. With F/L the range ends: load writes its element from idle.
// Add and count first locate the block of F by stepping one block a cycle. Add
// then does each read-modify-write step in turn, a step being one element of a
// partly covered block or one whole block's offset. Count reads one element and
// its offset per cycle from F to L, then delivers the result to the output slot.
// The element memory port and the offset memory port pace these steps.
// The result sits in an output register: a stalled receiver does not stop the
// next load or add; a further count waits at its end until the slot is free.
module range_add_count_below_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[1:0], first_index[11:2], last_index[21:12], operand_value[53:22]
    input  logic [racb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // below_count[10:0]
    output logic [racb_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [racb_pkg::CNT_W-1:0]      cfg_data
);

    localparam int NUM_BLOCKS = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int BLK_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int POS_W = $clog2(BLOCK_SIZE);
    localparam int CW = racb_pkg::CNT_W;
    localparam int VW = racb_pkg::VAL_W;
    localparam int OW = racb_pkg::OPD_W;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_LOCATE, ST_ADD_RD, ST_ADD_WR, ST_COUNT, ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          ecount_reg;
    logic [BLK_W-1:0]       clr_reg, clr_next;
    logic [CW-1:0]          i_reg, i_next;
    logic [CW-1:0]          last_reg, last_next;
    logic [CW-1:0]          base_reg, base_next;
    logic [BLK_W-1:0]       blk_reg, blk_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [OW-1:0]          opd_reg, opd_next;
    logic                   is_add_reg, is_add_next;
    logic                   whole_reg, whole_next;
    logic                   rdv_reg, rdv_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]          m_cnt_reg, m_cnt_next;

    logic [VW-1:0]          elem_mem [MAX_ELEMENTS];
    logic [VW-1:0]          off_mem [NUM_BLOCKS];
    logic [VW-1:0]          elem_rd_reg, off_rd_reg;

    logic                   elem_we, off_we;
    logic [ADDR_W-1:0]      elem_wa;
    logic [VW-1:0]          elem_wd, off_wd;
    logic [BLK_W-1:0]       off_wa;

    logic [1:0]             in_action;
    logic [racb_pkg::IDX_W-1:0] in_first, in_last;
    logic [OW-1:0]          in_opd;
    logic [CW-1:0]          used;
    logic                   range_ok, load_ok, s_fire, slot_free;
    logic signed [VW:0]     eff;
    logic                   below;

    assign in_action = s_tdata[1:0];
    assign in_first  = s_tdata[11:2];
    assign in_last   = s_tdata[21:12];
    assign in_opd    = s_tdata[53:22];

    assign used = (32'(ecount_reg) > 32'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : ecount_reg;
    assign range_ok = (in_first <= in_last) && ({1'b0, in_last} < used);
    assign load_ok  = {1'b0, in_first} < used;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(racb_pkg::M_TDATA_W-CW){1'b0}}, m_cnt_reg};

    assign eff = $signed({elem_rd_reg[VW-1], elem_rd_reg})
               + $signed({off_rd_reg[VW-1], off_rd_reg});
    assign below = eff < $signed({{(VW-OW+1){opd_reg[OW-1]}}, opd_reg});

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        i_next        = i_reg;
        last_next     = last_reg;
        base_next     = base_reg;
        blk_next      = blk_reg;
        pos_next      = pos_reg;
        opd_next      = opd_reg;
        is_add_next   = is_add_reg;
        whole_next    = whole_reg;
        rdv_next      = 1'b0;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        m_cnt_next    = m_cnt_reg;
        elem_we       = 1'b0;
        elem_wa       = ADDR_W'(i_reg);
        elem_wd       = racb_pkg::sat_add(elem_rd_reg, opd_reg);
        off_we        = 1'b0;
        off_wa        = blk_reg;
        off_wd        = racb_pkg::sat_add(off_rd_reg, opd_reg);

        unique case (state_reg)
            ST_CLEAR: begin
                off_we = 1'b1;
                off_wa = clr_reg;
                off_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == NUM_BLOCKS - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    opd_next  = in_opd;
                    i_next    = {1'b0, in_first};
                    last_next = {1'b0, in_last};
                    base_next = '0;
                    blk_next  = '0;
                    cnt_next  = '0;
                    unique case (in_action)
                        racb_pkg::ACT_LOAD: begin
                            if (load_ok) begin
                                elem_we = 1'b1;
                                elem_wa = ADDR_W'(in_first);
                                elem_wd = {{(VW-OW){in_opd[OW-1]}}, in_opd};
                            end
                        end
                        racb_pkg::ACT_ADD: begin
                            is_add_next = 1'b1;
                            if (range_ok) begin
                                state_next = ST_LOCATE;
                            end
                        end
                        racb_pkg::ACT_COUNT: begin
                            is_add_next = 1'b0;
                            state_next = range_ok ? ST_LOCATE : ST_DONE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOCATE: begin
                // step one block at a time to find the block holding the first index
                if (base_reg + CW'(BLOCK_SIZE) <= i_reg) begin
                    base_next = base_reg + CW'(BLOCK_SIZE);
                    blk_next  = blk_reg + 1'b1;
                end else begin
                    pos_next   = POS_W'(i_reg - base_reg);
                    state_next = is_add_reg ? ST_ADD_RD : ST_COUNT;
                end
            end
            ST_ADD_RD: begin
                if (i_reg > last_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    whole_next = (pos_reg == '0)
                              && (i_reg + CW'(BLOCK_SIZE - 1) <= last_reg);
                    state_next = ST_ADD_WR;
                end
            end
            ST_ADD_WR: begin
                state_next = ST_ADD_RD;
                if (whole_reg) begin
                    off_we   = 1'b1;
                    i_next   = i_reg + CW'(BLOCK_SIZE);
                    blk_next = blk_reg + 1'b1;
                end else begin
                    elem_we = 1'b1;
                    i_next  = i_reg + 1'b1;
                    if (pos_reg == POS_W'(BLOCK_SIZE - 1)) begin
                        pos_next = '0;
                        blk_next = blk_reg + 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_COUNT: begin
                // read issued this cycle is compared in the next
                if (rdv_reg && below) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (i_reg > last_reg) begin
                    state_next = ST_DONE;
                end else begin
                    rdv_next = 1'b1;
                    i_next   = i_reg + 1'b1;
                    if (pos_reg == POS_W'(BLOCK_SIZE - 1)) begin
                        pos_next = '0;
                        blk_next = blk_reg + 1'b1;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_cnt_next    = cnt_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            ecount_reg   <= CW'(1024);
            m_tvalid_reg <= 1'b0;
            rdv_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            rdv_reg      <= rdv_next;
            if (cfg_valid && cfg_ready) begin
                ecount_reg <= cfg_data;
            end
        end
        i_reg      <= i_next;
        last_reg   <= last_next;
        base_reg   <= base_next;
        blk_reg    <= blk_next;
        pos_reg    <= pos_next;
        opd_reg    <= opd_next;
        is_add_reg <= is_add_next;
        whole_reg  <= whole_next;
        cnt_reg    <= cnt_next;
        m_cnt_reg  <= m_cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (elem_we) begin
            elem_mem[elem_wa] <= elem_wd;
        end
        elem_rd_reg <= elem_mem[ADDR_W'(i_reg)];
    end

    always_ff @(posedge aclk) begin
        if (off_we) begin
            off_mem[off_wa] <= off_wd;
        end
        off_rd_reg <= off_mem[blk_reg];
    end

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !s_tready)
        else $error("input taken before offset clear finished");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> 32'(m_tdata) <= MAX_ELEMENTS)
        else $error("count exceeds element capacity");

    a_range_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && range_ok
        && (in_action == racb_pkg::ACT_ADD || in_action == racb_pkg::ACT_COUNT)
        |=> !s_tready)
        else $error("range command did not occupy the sequencer");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");
`endif

endmodule

[tb/tb_range_add_count_below_unit.sv]
`timescale 1ns / 100ps

module tb_range_add_count_below_unit;

    localparam int NUM_ELEM = 1024;
    localparam int BLK = 32;
    localparam int NUM_BLK = NUM_ELEM / BLK;
    localparam int VW = racb_pkg::VAL_W;
    localparam int OW = racb_pkg::OPD_W;
    localparam int CW = racb_pkg::CNT_W;
    // longest command: count over the whole array, plus margin
    localparam int DRAIN_CYCLES = 2200;
    localparam longint CYCLE_LIMIT = 8000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [racb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [racb_pkg::M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CW-1:0] cfg_data = '0;

    // shadow of the array, its block offsets and the element_count register
    logic signed [VW-1:0] shadow_elem [NUM_ELEM];
    logic signed [VW-1:0] shadow_ofs [NUM_BLK];
    int unsigned elem_count_reg;

    logic [CW-1:0] counts_due [$];
    int errors = 0;
    longint cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;

    range_add_count_below_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= 3000;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (counts_due.size() == 0) begin
                report_mismatch($sformatf("unexpected count %0d", m_tdata[CW-1:0]));
            end else begin
                logic [CW-1:0] want;
                want = counts_due.pop_front();
                if (m_tdata[CW-1:0] !== want)
                    report_mismatch($sformatf("below_count %0d, expected %0d",
                                              m_tdata[CW-1:0], want));
            end
        end
    end

    function automatic logic signed [VW-1:0] clamp48(input logic signed [VW+1:0] v);
        if (v > $signed({2'b00, racb_pkg::S48_MAX})) return racb_pkg::S48_MAX;
        if (v < $signed({2'b11, racb_pkg::S48_MIN})) return racb_pkg::S48_MIN;
        return v[VW-1:0];
    endfunction

    // updates the shadow array; returns 1 with the count for a count command
    function automatic bit apply_command(input racb_pkg::action_t act,
                                         input int unsigned first,
                                         input int unsigned last,
                                         input logic signed [OW-1:0] opd,
                                         output logic [CW-1:0] below);
        int unsigned used;
        int unsigned i;
        bit ok;
        logic signed [VW+1:0] acc;
        logic signed [VW+1:0] thr;
        used = (elem_count_reg > NUM_ELEM) ? NUM_ELEM : elem_count_reg;
        ok = (first <= last) && (last < used);
        below = '0;
        thr = opd;
        case (act)
            racb_pkg::ACT_LOAD: begin
                if (first < used) shadow_elem[first] = opd;
                return 0;
            end
            racb_pkg::ACT_ADD: begin
                if (!ok) return 0;
                i = first;
                while (i <= last) begin
                    if (i % BLK == 0 && i + BLK - 1 <= last) begin
                        acc = shadow_ofs[i / BLK];
                        acc = acc + thr;
                        shadow_ofs[i / BLK] = clamp48(acc);
                        i += BLK;
                    end else begin
                        acc = shadow_elem[i];
                        acc = acc + thr;
                        shadow_elem[i] = clamp48(acc);
                        i++;
                    end
                end
                return 0;
            end
            racb_pkg::ACT_COUNT: begin
                if (ok) begin
                    for (i = first; i <= last; i++) begin
                        acc = shadow_elem[i];
                        acc = acc + shadow_ofs[i / BLK];
                        if (acc < thr) below++;
                    end
                end
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    task automatic send_cmd(input racb_pkg::action_t act, input int unsigned first,
                            input int unsigned last, input logic [OW-1:0] opd);
        logic [CW-1:0] below;
        logic [9:0] f10;
        logic [9:0] l10;
        f10 = first[9:0];
        l10 = last[9:0];
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, opd, l10, f10, act};
        do @(posedge aclk); while (!s_tready);
        if (apply_command(act, f10, l10, opd, below)) counts_due = {counts_due, below};
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (counts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input int unsigned v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v[CW-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        elem_count_reg = v[CW-1:0];
    endtask

    function automatic logic [OW-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4, 5: return $urandom_range(2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_fill();
        for (int i = 0; i < NUM_ELEM; i++) send_cmd(racb_pkg::ACT_LOAD, i, 0, $urandom);
    endtask

    task automatic test_directed();
        send_cmd(racb_pkg::ACT_LOAD, 0, 0, 32'h8000_0000);
        send_cmd(racb_pkg::ACT_LOAD, 1023, 0, 32'h7fff_ffff);
        send_cmd(racb_pkg::ACT_COUNT, 0, 1023, 32'h7fff_ffff);
        send_cmd(racb_pkg::ACT_COUNT, 0, 1023, 32'h8000_0000);
        send_cmd(racb_pkg::ACT_ADD, 0, 1023, 32'h8000_0000);
        send_cmd(racb_pkg::ACT_COUNT, 0, 1023, 32'h0000_0000);
        send_cmd(racb_pkg::ACT_ADD, 5, 70, 32'h0000_1234);
        send_cmd(racb_pkg::ACT_ADD, 32, 63, 32'h7fff_ffff);
        send_cmd(racb_pkg::ACT_COUNT, 3, 72, 32'hffff_ff00);
        send_cmd(racb_pkg::ACT_COUNT, 40, 39, 32'h7fff_ffff);   // reversed
        send_cmd(racb_pkg::ACT_ADD, 900, 800, 32'h7fff_ffff);   // reversed, no effect
        send_cmd(racb_pkg::ACT_COUNT, 1023, 1023, 32'h7fff_ffff);
        send_cmd(racb_pkg::ACT_NONE, 1023, 1023, 32'hffff_ffff);
        send_cmd(racb_pkg::ACT_COUNT, 0, 0, 32'h8000_0001);
        send_cmd(racb_pkg::ACT_ADD, 31, 32, 32'hffff_ffff);
        send_cmd(racb_pkg::ACT_COUNT, 30, 33, 32'h0000_0000);
    endtask

    task automatic test_random(input int n);
        int unsigned used;
        int unsigned f;
        int unsigned l;
        int unsigned len;
        int r;
        racb_pkg::action_t act;
        used = (elem_count_reg > NUM_ELEM) ? NUM_ELEM : elem_count_reg;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            act = (r < 20) ? racb_pkg::ACT_LOAD : (r < 57) ? racb_pkg::ACT_ADD
                : (r < 96) ? racb_pkg::ACT_COUNT : racb_pkg::ACT_NONE;
            r = $urandom_range(99);
            len = (r < 70) ? $urandom_range(40) : (r < 95) ? $urandom_range(200)
                                                            : $urandom_range(1023);
            if (used == 0 || $urandom_range(9) == 0) begin
                f = $urandom_range(1023);
                l = $urandom_range(1023);
            end else begin
                f = $urandom_range(used - 1);
                l = (f + len > 1023) ? 1023 : f + len;
                if ($urandom_range(4) == 0 && used > 1) l = used - 1;
                if ($urandom_range(19) == 0) {f, l} = {l, f};
            end
            send_cmd(act, f, l, pick_operand());
            if (k == n / 2) drain();   // sender waits for every count to come back
        end
    endtask

    task automatic test_backpressure();
        hold_reqs++;
        for (int k = 0; k < 12; k++)
            send_cmd(k % 2 ? racb_pkg::ACT_COUNT : racb_pkg::ACT_ADD, k, k + 20, $urandom);
    endtask

    initial begin
        for (int i = 0; i < NUM_ELEM; i++) shadow_elem[i] = '0;
        for (int b = 0; b < NUM_BLK; b++) shadow_ofs[b] = '0;
        elem_count_reg = NUM_ELEM;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        write_count(NUM_ELEM);
        test_fill();
        test_directed();

        send_gap_pct = 34;
        recv_stall_pct = 80;
        test_random(150);
        test_backpressure();
        write_count(1);
        test_random(20);
        write_count(0);
        test_random(20);

        send_gap_pct = 80;
        recv_stall_pct = 34;
        write_count(2047);
        test_random(120);
        write_count(1000);
        test_random(80);

        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_count(NUM_ELEM);
        test_random(110);

        drain();
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
